>>> src/tbh_pkg.sv
// shared types, codes and constants of the triple buffer handoff block
package tbh_pkg;

  localparam int unsigned NUM_BUF    = 3;
  localparam int unsigned BUF_W      = 2;
  localparam int unsigned STAY_W     = 7;
  localparam logic [STAY_W-1:0] STAY_MAX         = 7'd127;
  localparam logic [STAY_W-1:0] STAY_LIMIT_RESET = 7'd100;

  typedef enum logic [1:0] {
    REQ_CONS_ACQUIRE = 2'd0,
    REQ_CONS_RELEASE = 2'd1,
    REQ_PROD_ACQUIRE = 2'd2,
    REQ_PROD_RELEASE = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    OWN_ANY    = 2'd0,
    OWN_READER = 2'd1,
    OWN_WRITER = 2'd2
  } owner_t;

  typedef enum logic [1:0] {
    PUT_NONE  = 2'd0,
    PUT_NEXT  = 2'd1,
    PUT_OTHER = 2'd2,
    PUT_KEPT  = 2'd3
  } put_outcome_t;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [BUF_W-1:0] buf_index;
  } req_item_t;

  typedef struct packed {
    logic [BUF_W-1:0] granted_buffer;
    logic             fault;
    logic [1:0]       put_outcome;
  } rsp_item_t;

  // buffer after b, wrapping over three
  function automatic logic [BUF_W-1:0] wrap_next(input logic [BUF_W-1:0] b);
    return (b >= 2'd2) ? 2'd0 : b + 2'd1;
  endfunction

endpackage

>>> src/tbh_ctrl.sv
// ownership state of the three buffers and the per-request update
module tbh_ctrl
  import tbh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  req_item_t         item,
  input  logic              cfg_we,
  input  logic [STAY_W-1:0] cfg_data,
  output rsp_item_t         rsp
);

  owner_t            owner_mark [NUM_BUF];
  owner_t            owner_mark_next [NUM_BUF];
  logic [BUF_W-1:0]  reader_next, reader_next_next;
  logic [BUF_W-1:0]  writer_next, writer_next_next;
  logic [NUM_BUF-1:0] reader_holds, reader_holds_next;
  logic [STAY_W-1:0] stay_count, stay_count_next;
  logic [STAY_W-1:0] stay_limit;

  always_comb begin
    logic [BUF_W-1:0] idx;
    logic [BUF_W-1:0] n1;
    logic [BUF_W-1:0] n2;
    idx = item.buf_index;
    n1  = wrap_next(idx);
    n2  = wrap_next(n1);
    for (int i = 0; i < NUM_BUF; i++) owner_mark_next[i] = owner_mark[i];
    reader_next_next  = reader_next;
    writer_next_next  = writer_next;
    reader_holds_next = reader_holds;
    stay_count_next   = stay_count;
    rsp = '0;
    case (req_kind_t'(item.req_type))
      REQ_CONS_ACQUIRE: begin
        rsp.fault = (owner_mark[reader_next] == OWN_WRITER);
        owner_mark_next[reader_next] = OWN_READER;
        reader_holds_next[reader_next] = 1'b1;
        rsp.granted_buffer = reader_next;
      end
      REQ_CONS_RELEASE: begin
        if (idx >= BUF_W'(NUM_BUF)) begin
          rsp.fault = 1'b1;
        end else begin
          reader_holds_next[idx] = 1'b0;
          for (int i = 0; i < NUM_BUF; i++) owner_mark_next[i] = OWN_ANY;
        end
      end
      REQ_PROD_ACQUIRE: begin
        rsp.fault = (writer_next == reader_next) ||
                    (owner_mark[writer_next] == OWN_READER) ||
                    reader_holds[writer_next];
        rsp.granted_buffer = writer_next;
      end
      REQ_PROD_RELEASE: begin
        if (idx >= BUF_W'(NUM_BUF)) begin
          rsp.fault = 1'b1;
        end else begin
          rsp.fault = reader_holds[idx];
          if (owner_mark[n1] != OWN_READER) begin
            rsp.put_outcome       = PUT_NEXT;
            owner_mark_next[idx]  = OWN_READER;
            owner_mark_next[n1]   = OWN_WRITER;
            reader_next_next      = idx;
            writer_next_next      = n1;
            stay_count_next       = '0;
          end else if (owner_mark[n2] != OWN_READER) begin
            rsp.put_outcome       = PUT_OTHER;
            owner_mark_next[idx]  = OWN_READER;
            owner_mark_next[n2]   = OWN_WRITER;
            reader_next_next      = idx;
            writer_next_next      = n2;
            stay_count_next       = '0;
          end else begin
            rsp.put_outcome      = PUT_KEPT;
            owner_mark_next[idx] = OWN_WRITER;
            if (stay_count >= stay_limit) rsp.fault = 1'b1;
            if (stay_count < STAY_MAX) stay_count_next = stay_count + 7'd1;
          end
        end
      end
      default: begin
        rsp = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BUF; i++) owner_mark[i] <= OWN_WRITER;
      reader_next  <= 2'd1;
      writer_next  <= 2'd0;
      reader_holds <= '0;
      stay_count   <= '0;
      stay_limit   <= STAY_LIMIT_RESET;
    end else begin
      if (cfg_we) begin
        stay_limit <= cfg_data;
      end
      if (fire) begin
        for (int i = 0; i < NUM_BUF; i++) owner_mark[i] <= owner_mark_next[i];
        reader_next  <= reader_next_next;
        writer_next  <= writer_next_next;
        reader_holds <= reader_holds_next;
        stay_count   <= stay_count_next;
      end
    end
  end

endmodule

>>> src/tbh_out_queue.sv
// two-entry result queue between the update logic and the result port
module tbh_out_queue
  import tbh_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  rsp_item_t push_item,
  output logic      room,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_item_t rsp
);

  rsp_item_t   entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        pop;
  logic        do_push;

  assign room      = (count != 2'd2);
  assign rsp_valid = (count != 2'd0);
  assign rsp       = entry[rd_ptr];
  assign pop       = rsp_valid && !rsp_stall;
  assign do_push   = push && room;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({do_push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> src/triple_buffer_handoff_core.sv
// top level of the triple buffer handoff block
// Tracks which of three frame buffers the producer and the consumer own. One request
// item per cycle is accepted while req_stall is low, and each gives exactly one
// result item. A request is held in an input register; once the output queue has
// room, the ownership update runs and its result is written into that two-entry
// queue, which feeds the result port. req_stall rises only when that queue is full.
// The user must write stay_limit through cfg_data (always ready) only while no
// request is in flight; the block itself does not enforce this.
module triple_buffer_handoff_core
  import tbh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  req_item_t         req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output rsp_item_t         rsp,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [STAY_W-1:0] cfg_data
);

  logic      hold_valid, hold_valid_next;
  req_item_t hold_item;
  logic      room;
  logic      advance;
  logic      accept;
  rsp_item_t result;

  assign cfg_ready = 1'b1;
  assign advance   = hold_valid && room;
  assign req_stall = hold_valid && !room;
  assign accept    = req_valid && !req_stall;

  always_comb begin
    hold_valid_next = hold_valid;
    if (accept) begin
      hold_valid_next = 1'b1;
    end else if (advance) begin
      hold_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= hold_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_item <= req;
    end
  end

  tbh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .fire     (advance),
    .item     (hold_item),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .rsp      (result)
  );

  tbh_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (advance),
    .push_item (result),
    .room      (room),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // stall only while an item waits in the input register
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> hold_valid)
    else $error("request stalled with empty input register");

  // after a processed item, the result port shows a valid item next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> rsp_valid)
    else $error("processed item not queued");

  // producer releases never grant a buffer
  a_release_no_grant: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.put_outcome != PUT_NONE) |-> (rsp.granted_buffer == 2'd0))
    else $error("producer release result carries a grant");

  // granted buffer always names one of the three
  a_grant_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.granted_buffer != 2'd3))
    else $error("granted buffer out of range");

endmodule
